### design/assert_macros.svh
// assertion macros shared by the rtl of the character lcd text writer
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### design/clcd_pkg.sv
// types and constants of the character lcd text writer
// no dependencies; used by the stream interface users and the core
`default_nettype none

package clcd_pkg;

    // item opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_CHAR  = 1'b1;

    // control characters
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_RAW_ONE = 8'h07;
    localparam logic [7:0] CH_RAW_ON  = 8'h08;
    localparam logic [7:0] CH_RAW_END = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_CYR_LO  = 8'd192;

    localparam logic [7:0] CMD_SET_ADDR = 8'h80;

    // display address of column 0 of each row
    localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    // cyrillic code page map for codes 192..255
    localparam logic [7:0] CYR_ROM [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    // translation mode
    typedef enum logic [2:0] {
        XLAT_ON      = 3'b001,
        XLAT_RAW_ONE = 3'b010,
        XLAT_RAW     = 3'b100
    } t_xlat_mode;

    typedef struct packed {
        logic       opcode;
        logic [2:0] start_row;
        logic [4:0] start_column;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic       is_data;
        logic [7:0] lcd_byte;
    } t_out_item;

endpackage

`default_nettype wire

### design/clcd_stream_if.sv
// valid/ready stream channel carrying one payload per transaction
// payload type is given by the instantiating level (see clcd_pkg)
`default_nettype none

interface clcd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/char_lcd_text_writer_core.sv
// character lcd text writer: strings in, set-address commands and data bytes out
// depends on clcd_pkg, clcd_stream_if and assert_macros.svh
//
//   port    dir  payload      per transaction
//   i_in    in   t_in_item    start of a string or one character
//   o_out   out  t_out_item   zero or one command/data byte per input
//
// one item per cycle sustained while the result is not stalled; an item passes
// via the input register, then the decode and rom lookup into the result register
// state updates happen as an item leaves the input register, so the next item
// always sees them; a stalled result holds both stages, the input register
// still fills while it is empty
// synchronous active-low reset returns the writer to idle, translating
`default_nettype none

`include "assert_macros.svh"

module char_lcd_text_writer_core #(
    parameter int LINE_WIDTH = 20,
    parameter int ROW_COUNT  = 4
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    clcd_stream_if.sink   i_in,
    clcd_stream_if.source o_out
);
    import clcd_pkg::*;

    localparam int COL_W_LW = $clog2(LINE_WIDTH + 1);
    localparam int COL_W    = (COL_W_LW > 5) ? COL_W_LW : 5;

    // input register
    logic       r_in_valid;
    t_in_item   r_in;

    // string state
    logic             r_active, n_active;
    logic [1:0]       r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    t_xlat_mode       r_mode, n_mode;

    // result register
    logic       r_out_valid;
    t_out_item  r_out;

    logic       w_out_free;
    logic       w_fire;
    logic       w_emit;
    logic       w_is_data;
    logic [7:0] w_data;
    logic [1:0] w_addr_row;
    logic [COL_W-1:0] w_addr_col;
    logic [7:0] w_addr;
    logic [2:0] w_next_row;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_out_free;

    assign i_in.ready    = !r_in_valid || w_out_free;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign w_next_row = {1'b0, r_row} + 3'd1;
    assign w_addr     = CMD_SET_ADDR | (ROW_BASE[w_addr_row] + 8'(w_addr_col));

    always_comb begin
        n_active   = r_active;
        n_row      = r_row;
        n_col      = r_col;
        n_mode     = r_mode;
        w_emit     = 1'b0;
        w_is_data  = 1'b0;
        w_data     = r_in.char_code;
        w_addr_row = r_in.start_row[1:0];
        w_addr_col = COL_W'(r_in.start_column);

        if (r_in.opcode == OP_START) begin
            n_mode = XLAT_ON;
            if (r_in.start_row < 3'(ROW_COUNT)) begin
                n_active = 1'b1;
                n_row    = r_in.start_row[1:0];
                n_col    = COL_W'(r_in.start_column);
                w_emit   = 1'b1;
            end else begin
                n_active = 1'b0;
            end
        end else if (r_active) begin
            case (r_in.char_code)
                CH_NUL: begin
                    n_active = 1'b0;
                end
                CH_RAW_ONE: begin
                    n_mode = XLAT_RAW_ONE;
                end
                CH_RAW_ON: begin
                    n_mode = XLAT_RAW;
                end
                CH_RAW_END: begin
                    n_mode = XLAT_ON;
                end
                CH_LF, CH_CR: begin
                    n_col      = '0;
                    w_addr_row = w_next_row[1:0];
                    w_addr_col = '0;
                    if (w_next_row >= 3'(ROW_COUNT)) begin
                        n_active = 1'b0;
                    end else begin
                        n_row  = w_next_row[1:0];
                        w_emit = 1'b1;
                    end
                end
                default: begin
                    if (r_col >= COL_W'(LINE_WIDTH)) begin
                        n_active = 1'b0;
                    end else begin
                        n_col     = COL_W'(r_col + 1'b1);
                        w_emit    = 1'b1;
                        w_is_data = 1'b1;
                        if (r_in.char_code >= CH_CYR_LO && r_mode == XLAT_ON) begin
                            w_data = CYR_ROM[r_in.char_code[5:0]];
                        end
                        if (r_mode == XLAT_RAW_ONE) begin
                            n_mode = XLAT_ON;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_mode      <= XLAT_ON;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= w_emit;
                r_active    <= n_active;
                r_row       <= n_row;
                r_col       <= n_col;
                r_mode      <= n_mode;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
        if (w_fire) begin
            r_out.is_data <= w_is_data;
            r_out.lcd_byte <= w_is_data ? w_data : w_addr;
        end
    end

    // a character while no string is open gives no transaction
    `ASSERT_NEXT(a_idle_char_silent, i_clk, i_rst_n, w_fire && r_in.opcode == OP_CHAR && !r_active, !r_out_valid, "character while idle produced a result")
    // every command byte is a set-address command
    `ASSERT_IMPL(a_cmd_is_addr, i_clk, i_rst_n, r_out_valid && !r_out.is_data, r_out.lcd_byte[7], "command byte without set-address bit")
    // a held item stays put while the result stage is blocked
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_out_free, r_in_valid && $stable(r_in), "input register lost a stalled item")

endmodule

`default_nettype wire

### tb/tb_char_lcd_text_writer_core.sv
// self-checking testbench for char_lcd_text_writer_core: directed and random strings in,
// command and data bytes checked against a behavioral tracker of the writer state
// depends on clcd_pkg, clcd_stream_if and the core rtl
`timescale 1ns / 100ps

module tb_char_lcd_text_writer_core;
    import clcd_pkg::*;

    localparam int LINE_WIDTH  = 20;
    localparam int ROW_COUNT   = 4;
    localparam int ITEM_TARGET = 750;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        t_in_item item;
        bit       drain_first;
    } t_pending;

    logic i_clk;
    logic i_rst_n;

    clcd_stream_if #(.t_payload(t_in_item))  in_ch ();
    clcd_stream_if #(.t_payload(t_out_item)) out_ch ();

    char_lcd_text_writer_core #(
        .LINE_WIDTH(LINE_WIDTH),
        .ROW_COUNT (ROW_COUNT)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // tracked writer state
    bit         wr_open;
    logic [1:0] wr_row;
    logic [4:0] wr_col;
    t_xlat_mode wr_mode;

    t_pending  item_q[$];
    t_out_item lcd_bytes_due[$];

    int items_total;
    int items_taken;
    int results_seen;
    int err_count;
    int send_gap;
    int stall_left;
    int quiet_cycles;
    bit send_quiet;
    bit recv_quiet;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic t_out_item address_cmd();
        t_out_item res;
        res.is_data  = 1'b0;
        res.lcd_byte = CMD_SET_ADDR | (ROW_BASE[wr_row] + {3'b000, wr_col});
        return res;
    endfunction

    // advances the writer state by one accepted transaction and queues its byte, if any
    task automatic track_lcd_writer(input t_in_item it);
        t_out_item  res;
        bit         has_res;
        logic [7:0] code;
        logic [5:0] rom_idx;
        res     = '0;
        has_res = 1'b0;
        code    = it.char_code;
        if (it.opcode == OP_START) begin
            wr_mode = XLAT_ON;
            if (it.start_row >= ROW_COUNT) begin
                wr_open = 1'b0;
            end else begin
                wr_open = 1'b1;
                wr_row  = it.start_row[1:0];
                wr_col  = it.start_column;
                res     = address_cmd();
                has_res = 1'b1;
            end
        end else if (wr_open) begin
            case (code)
                CH_NUL:     wr_open = 1'b0;
                CH_RAW_ONE: wr_mode = XLAT_RAW_ONE;
                CH_RAW_ON:  wr_mode = XLAT_RAW;
                CH_RAW_END: wr_mode = XLAT_ON;
                CH_LF, CH_CR: begin
                    wr_col = '0;
                    if (wr_row >= ROW_COUNT - 1) begin
                        wr_open = 1'b0;
                    end else begin
                        wr_row  = wr_row + 2'd1;
                        res     = address_cmd();
                        has_res = 1'b1;
                    end
                end
                default: begin
                    if (wr_col >= LINE_WIDTH) begin
                        wr_open = 1'b0;
                    end else begin
                        wr_col = wr_col + 5'd1;
                        if (code >= CH_CYR_LO && wr_mode == XLAT_ON) begin
                            rom_idx = code - CH_CYR_LO;
                            code    = CYR_ROM[rom_idx];
                        end
                        if (wr_mode == XLAT_RAW_ONE) wr_mode = XLAT_ON;
                        res.is_data  = 1'b1;
                        res.lcd_byte = code;
                        has_res      = 1'b1;
                    end
                end
            endcase
        end
        if (has_res) lcd_bytes_due.push_back(res);
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("ERROR @%0t: %s: got 0x%02h, want 0x%02h", $time, what, got, want);
        err_count++;
    endtask

    function automatic int idle_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_start(input logic [2:0] row, input logic [4:0] col,
                              input bit drain = 1'b0);
        t_pending p;
        p.item.opcode       = OP_START;
        p.item.start_row    = row;
        p.item.start_column = col;
        p.item.char_code    = $urandom_range(0, 255);
        p.drain_first       = drain;
        item_q.push_back(p);
        items_total++;
    endtask

    task automatic push_char(input logic [7:0] code);
        t_pending p;
        p.item.opcode       = OP_CHAR;
        p.item.start_row    = $urandom_range(0, 7);
        p.item.start_column = $urandom_range(0, 31);
        p.item.char_code    = code;
        p.drain_first       = 1'b0;
        item_q.push_back(p);
        items_total++;
    endtask

    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(8'h20, 8'h7e);
        if (r < 75) return $urandom_range(192, 255);
        if (r < 81) return $urandom_range(128, 191);
        if (r < 85) return CH_RAW_ONE;
        if (r < 89) return CH_RAW_ON;
        if (r < 93) return CH_RAW_END;
        if (r < 95) return CH_CR;
        if (r < 97) return CH_LF;
        return $urandom_range(0, 255);
    endfunction

    // stimulus and end of run
    initial begin
        int n_gen;
        int len;
        int r;
        bit drain;
        logic [2:0] row;
        logic [4:0] col;

        // directed: rom edges, mode controls, row walk, line end, restarts
        push_start(3'd0, 5'd0);
        push_char(8'h41);
        push_char(8'hC0);
        push_char(8'hFF);
        push_char(8'hBF);
        push_char(CH_RAW_ONE);
        push_char(8'hC8);
        push_char(8'hC8);
        push_char(CH_RAW_ON);
        push_char(CH_RAW_ONE);
        push_char(8'hE0);
        push_char(8'hE0);
        push_char(CH_RAW_ONE);
        push_char(CH_RAW_ON);
        push_char(CH_CR);
        push_char(8'hF0);
        push_char(CH_RAW_END);
        push_char(CH_LF);
        push_char(CH_CR);
        push_char(CH_LF);
        push_char(8'h78);
        push_start(3'd5, 5'd0);
        push_start(3'd3, 5'd19);
        push_char(8'h61);
        push_char(8'h62);
        push_start(3'd2, 5'd31);
        push_char(8'h71);
        push_start(3'd1, 5'd5);
        push_char(CH_NUL);
        push_char(8'h7a);
        push_start(3'd0, 5'd3);
        push_char(CH_RAW_ON);
        push_start(3'd7, 5'd31);
        push_start(3'd1, 5'd0);
        push_char(8'hD0);

        // random: mostly well-formed strings, some noise and broken starts
        n_gen = 0;
        drain = 1'b1;
        while (n_gen < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                push_char($urandom_range(0, 255));
            end else begin
                row = (r < 12) ? $urandom_range(4, 7) : $urandom_range(0, 3);
                col = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 31)
                                                  : $urandom_range(0, 19);
                push_start(row, col, drain);
                n_gen++;
                len = $urandom_range(0, 24);
                for (int k = 0; k < len; k++) begin
                    push_char(random_char());
                    n_gen++;
                end
                if ($urandom_range(0, 3) != 0) begin
                    push_char(CH_NUL);
                    n_gen++;
                end
            end
            drain = ($urandom_range(0, 19) == 0);
        end

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (items_taken != items_total) @(posedge i_clk);
        while (lcd_bytes_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS char_lcd_text_writer_core");
        end else begin
            $display("FAIL char_lcd_text_writer_core");
        end
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
            wr_open  = 1'b0;
            wr_row   = '0;
            wr_col   = '0;
            wr_mode  = XLAT_ON;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                track_lcd_writer(in_ch.payload);
                items_taken++;
                if (items_taken % 50 == 0) send_quiet = ($urandom_range(0, 3) == 0);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (item_q.size() == 0 ||
                             (item_q[0].drain_first && lcd_bytes_due.size() != 0)) begin
                    // hold off until every outstanding byte has come back
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid   <= 1'b1;
                    in_ch.payload <= item_q[0].item;
                    void'(item_q.pop_front());
                    send_gap = idle_len(send_quiet);
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item due;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (results_seen % 50 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
                if (lcd_bytes_due.size() == 0) begin
                    flag_mismatch("transaction with nothing expected",
                                  out_ch.payload.lcd_byte, 8'h00);
                end else begin
                    due = lcd_bytes_due.pop_front();
                    if (out_ch.payload.is_data !== due.is_data)
                        flag_mismatch("is_data", {7'd0, out_ch.payload.is_data},
                                      {7'd0, due.is_data});
                    if (out_ch.payload.lcd_byte !== due.lcd_byte)
                        flag_mismatch("lcd_byte", out_ch.payload.lcd_byte, due.lcd_byte);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = idle_len(recv_quiet);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL char_lcd_text_writer_core");
                $finish;
            end
        end
    end

endmodule

### filelist.f
+incdir+design
design/clcd_pkg.sv
design/clcd_stream_if.sv
design/char_lcd_text_writer_core.sv
tb/tb_char_lcd_text_writer_core.sv
